// ===== rtl/btd_pkg.sv =====
// Shared types, status codes and helper functions for the byte-level token text decoder.
// Used by the front decoder, the entry queue, the byte expander and the top level.
package btd_pkg;

    localparam int unsigned CodeWidth = 21;
    localparam logic [CodeWidth-1:0] CodeMax = 21'h10ffff;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_RANGE     = 2'd2
    } status_t;

    // A queued result group: one to four output bytes, or one error result.
    typedef struct packed {
        status_t              status;
        logic [1:0]           cnt;
        logic [CodeWidth-1:0] code;
    } entry_t;

    typedef struct packed {
        logic       mapped;
        logic [7:0] value;
    } map_t;

    function automatic map_t code_to_byte(input logic [CodeWidth-1:0] cp);
        map_t       res;
        logic [8:0] shifted;
        shifted = cp[8:0] - 9'd162;
        res.mapped = 1'b1;
        res.value = cp[7:0];
        if ((cp >= 21'd33 && cp <= 21'd126) || (cp >= 21'd161 && cp <= 21'd172) ||
            (cp >= 21'd174 && cp <= 21'd288)) begin
            res.value = cp[7:0];
        end else if (cp >= 21'd289 && cp <= 21'd322) begin
            res.value = shifted[7:0];
        end else if (cp == 21'd323) begin
            res.value = 8'd173;
        end else begin
            res.mapped = 1'b0;
            res.value = 8'd0;
        end
        return res;
    endfunction

    function automatic logic [1:0] utf8_extra(input logic [CodeWidth-1:0] cp);
        logic [1:0] n;
        if (cp <= 21'h7f) begin
            n = 2'd0;
        end else if (cp <= 21'h7ff) begin
            n = 2'd1;
        end else if (cp <= 21'hffff) begin
            n = 2'd2;
        end else begin
            n = 2'd3;
        end
        return n;
    endfunction

    function automatic logic [7:0] entry_byte(input entry_t e, input logic [1:0] idx);
        logic [7:0] b;
        b = 8'd0;
        case (e.cnt)
            2'd0: begin
                b = e.code[7:0];
            end
            2'd1: begin
                case (idx)
                    2'd0:    b = {3'b110, e.code[10:6]};
                    default: b = {2'b10, e.code[5:0]};
                endcase
            end
            2'd2: begin
                case (idx)
                    2'd0:    b = {4'b1110, e.code[15:12]};
                    2'd1:    b = {2'b10, e.code[11:6]};
                    default: b = {2'b10, e.code[5:0]};
                endcase
            end
            default: begin
                case (idx)
                    2'd0:    b = {5'b11110, e.code[20:18]};
                    2'd1:    b = {2'b10, e.code[17:12]};
                    2'd2:    b = {2'b10, e.code[11:6]};
                    default: b = {2'b10, e.code[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/btd_front.sv =====
// Front stage: accepts text bytes, tracks UTF-8 sequence state and classifies each codepoint.
// Depends on btd_pkg; pushes one entry per result group into the entry queue.
module btd_front import btd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       drop_special,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_piece_byte,
    input  logic       s_piece_last,
    input  logic       s_token_special,
    input  logic       q_space,
    output logic       push_valid,
    output entry_t     push_entry
);

    logic [CodeWidth-1:0] acc_reg, acc_next;
    logic [1:0]           rem_reg, rem_next;
    logic                 discard_reg, discard_next;

    logic                 accept;
    logic [CodeWidth-1:0] acc_new;
    logic [1:0]           rem_new;
    logic                 err;
    logic                 done;
    map_t                 map;

    assign s_ready = q_space;
    assign accept  = s_valid & q_space;
    assign map     = code_to_byte(acc_new);

    always_comb begin
        acc_next     = acc_reg;
        rem_next     = rem_reg;
        discard_next = discard_reg;
        acc_new      = acc_reg;
        rem_new      = rem_reg;
        err          = 1'b0;
        done         = 1'b0;
        push_valid   = 1'b0;
        push_entry   = '{status: ST_OK, cnt: 2'd0, code: '0};
        if (accept) begin
            if (drop_special && s_token_special) begin
                if (s_piece_last) begin
                    acc_next     = '0;
                    rem_next     = 2'd0;
                    discard_next = 1'b0;
                end
            end else if (discard_reg) begin
                if (s_piece_last) begin
                    discard_next = 1'b0;
                end
            end else begin
                if (rem_reg == 2'd0) begin
                    if (s_piece_byte[7] == 1'b0) begin
                        acc_new = {14'd0, s_piece_byte[6:0]};
                        done    = 1'b1;
                    end else if (s_piece_byte[7:5] == 3'b110) begin
                        acc_new = {16'd0, s_piece_byte[4:0]};
                        rem_new = 2'd1;
                    end else if (s_piece_byte[7:4] == 4'b1110) begin
                        acc_new = {17'd0, s_piece_byte[3:0]};
                        rem_new = 2'd2;
                    end else if (s_piece_byte[7:3] == 5'b11110) begin
                        acc_new = {18'd0, s_piece_byte[2:0]};
                        rem_new = 2'd3;
                    end else begin
                        err = 1'b1;
                    end
                end else if (s_piece_byte[7:6] != 2'b10) begin
                    err = 1'b1;
                end else begin
                    acc_new = {acc_reg[CodeWidth-7:0], s_piece_byte[5:0]};
                    rem_new = rem_reg - 2'd1;
                    done    = (rem_reg == 2'd1);
                end

                if (!err && !done && s_piece_last) begin
                    err = 1'b1;
                end

                if (err) begin
                    push_valid        = 1'b1;
                    push_entry.status = ST_MALFORMED;
                end else if (done) begin
                    push_valid = 1'b1;
                    if (acc_new > CodeMax) begin
                        err               = 1'b1;
                        push_entry.status = ST_RANGE;
                    end else if (map.mapped) begin
                        push_entry.code = {13'd0, map.value};
                    end else begin
                        push_entry.cnt  = utf8_extra(acc_new);
                        push_entry.code = acc_new;
                    end
                end

                if (err) begin
                    acc_next     = '0;
                    rem_next     = 2'd0;
                    discard_next = !s_piece_last;
                end else if (done) begin
                    acc_next = '0;
                    rem_next = 2'd0;
                end else begin
                    acc_next = acc_new;
                    rem_next = rem_new;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            rem_reg     <= 2'd0;
            discard_reg <= 1'b0;
        end else begin
            acc_reg     <= acc_next;
            rem_reg     <= rem_next;
            discard_reg <= discard_next;
        end
    end

endmodule

// ===== rtl/btd_queue.sv =====
// Short entry queue between the front decoder and the byte expander.
// Depends on btd_pkg for the entry type.
module btd_queue import btd_pkg::*; #(
    parameter int unsigned DEPTH = 4
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    output logic   space,
    input  logic   pop,
    output logic   head_valid,
    output entry_t head_entry
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
    localparam logic [CW-1:0] Full = CW'(DEPTH);

    entry_t          mem [DEPTH];
    logic [AW-1:0]   wr_reg, wr_next;
    logic [AW-1:0]   rd_reg, rd_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    assign space      = (cnt_reg != Full);
    assign head_valid = (cnt_reg != '0);
    assign head_entry = mem[rd_reg];

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_next = (wr_reg == LastIdx) ? '0 : wr_reg + AW'(1);
        end
        if (pop) begin
            rd_next = (rd_reg == LastIdx) ? '0 : rd_reg + AW'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== rtl/btd_back.sv =====
// Back stage: expands each queued entry into one to four result transactions.
// Depends on btd_pkg; drives the registered result channel.
module btd_back import btd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       head_valid,
    input  entry_t     head_entry,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [1:0] m_status,
    output logic       m_last
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    status_t    status_reg;
    logic       last_reg;
    logic       load;
    logic       final_byte;

    assign load       = head_valid && (!valid_reg || m_ready);
    assign final_byte = (idx_reg == head_entry.cnt);
    assign pop        = load && final_byte;

    assign m_valid    = valid_reg;
    assign m_out_byte = byte_reg;
    assign m_status   = status_reg;
    assign m_last     = last_reg;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = final_byte ? 2'd0 : idx_reg + 2'd1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg   <= entry_byte(head_entry, idx_reg);
            status_reg <= head_entry.status;
            last_reg   <= final_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// ===== rtl/byte_level_token_text_decoder_unit.sv =====
// An input byte's result is written into the entry queue and then loaded into the output register before it leaves.
// Throughput: one input byte per cycle; the output register delivers one result byte per cycle while m_ready is high,
// so a codepoint re-encoded as n bytes holds the expander until all n bytes are out while the queue absorbs input.
// Input is stalled only when the entry queue of QUEUE_DEPTH entries is full.
// Reset (aresetn low, synchronous) clears the sequence state, the queue and the output valid flag,
// and turns off the dropping of special-token bytes.
module byte_level_token_text_decoder_unit import btd_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_piece_byte,
    input  logic       s_piece_last,
    input  logic       s_token_special,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [1:0] m_status,
    output logic       m_last
);

    logic   skip_reg;
    logic   q_space;
    logic   push_valid;
    entry_t push_entry;
    logic   pop;
    logic   head_valid;
    entry_t head_entry;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            skip_reg <= cfg_wr_data;
        end
    end

    btd_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .drop_special    (skip_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_piece_byte    (s_piece_byte),
        .s_piece_last    (s_piece_last),
        .s_token_special (s_token_special),
        .q_space         (q_space),
        .push_valid      (push_valid),
        .push_entry      (push_entry)
    );

    btd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push_valid),
        .push_entry (push_entry),
        .space      (q_space),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    btd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_status   (m_status),
        .m_last     (m_last)
    );

endmodule
